// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cdt_pkg.sv -----
// Shared types and constants for the countdown timer with alarm pattern.
// Used by every module of the block; depends on nothing.
package cdt_pkg;

    typedef enum logic [2:0] {
        MODE_RESET   = 3'd0,
        MODE_DELAY   = 3'd1,
        MODE_RUN     = 3'd2,
        MODE_ALARM   = 3'd3,
        MODE_RESTART = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_STOP      = 2'd0,
        PH_SOUND     = 2'd1,
        PH_SLICE_OFF = 2'd2,
        PH_LONG_OFF  = 2'd3
    } phase_t;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLICK = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_TICKS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY_TICKS = 2'd1;

    localparam logic [15:0] SECOND_TICKS_RST      = 16'd1000;
    localparam logic [15:0] START_DELAY_TICKS_RST = 16'd5000;

    localparam logic [6:0] PRESET_90 = 7'd90;
    localparam logic [6:0] PRESET_60 = 7'd60;
    localparam logic [6:0] PRESET_45 = 7'd45;
    localparam logic [6:0] PRESET_30 = 7'd30;
    localparam logic [6:0] PRESET_15 = 7'd15;
    localparam logic [6:0] TENS_MIN  = 7'd10;

    // Pattern timing in ticks; slice counter runs mod 50 in step with the 1000-tick period.
    localparam logic [5:0] SLICE_LAST    = 6'd49;
    localparam logic [9:0] LONG_PAUSE_AT = 10'd500;
    localparam logic [9:0] PERIOD_TICKS  = 10'd1000;

    typedef struct packed {
        logic second;
        logic delay_done;
        logic slice;
        logic long_pause;
        logic period;
    } tick_flags_t;

    typedef struct packed {
        logic delay_count;
        logic second;
        logic delay_done;
        logic slice;
        logic long_pause;
        logic period;
    } tick_clear_t;

    typedef struct packed {
        logic [6:0] seconds_left;
        logic       tens_digit_on;
        logic [2:0] timer_mode;
        logic       tone_enable;
    } result_t;

endpackage

// ----- rtl/cdt_ticks.sv -----
// Tick counters for the second, the start delay window and the alarm pattern.
// Raises the event flags; the controller clears them. Depends on cdt_pkg.
module cdt_ticks (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [15:0]          second_ticks,
    input  logic [15:0]          start_delay_ticks,
    input  cdt_pkg::tick_clear_t clr,
    output cdt_pkg::tick_flags_t flags
);

    logic [15:0] second_count_reg, second_count_next;
    logic [15:0] delay_count_reg, delay_count_next;
    logic [9:0]  pattern_count_reg, pattern_count_next;
    logic [5:0]  slice_count_reg, slice_count_next;
    cdt_pkg::tick_flags_t flags_reg, flags_next;

    logic [15:0] sc_inc, dc_inc;
    logic [9:0]  pc_inc;
    logic        sec_hit, dly_hit, per_hit, slc_hit, lng_hit;

    always_comb
    begin
        sc_inc  = second_count_reg + 16'd1;
        dc_inc  = delay_count_reg + 16'd1;
        pc_inc  = pattern_count_reg + 10'd1;
        sec_hit = (sc_inc >= second_ticks);
        dly_hit = (dc_inc >= start_delay_ticks);
        per_hit = (pc_inc >= cdt_pkg::PERIOD_TICKS);
        slc_hit = (slice_count_reg == cdt_pkg::SLICE_LAST);
        lng_hit = (pc_inc == cdt_pkg::LONG_PAUSE_AT);

        flags.second     = flags_reg.second     | sec_hit;
        flags.delay_done = flags_reg.delay_done | dly_hit;
        flags.slice      = flags_reg.slice      | slc_hit;
        flags.long_pause = flags_reg.long_pause | lng_hit;
        flags.period     = flags_reg.period     | per_hit;

        second_count_next  = sec_hit ? 16'd0 : sc_inc;
        delay_count_next   = (clr.delay_count || dly_hit) ? 16'd0 : dc_inc;
        pattern_count_next = per_hit ? 10'd0 : pc_inc;
        slice_count_next   = slc_hit ? 6'd0 : slice_count_reg + 6'd1;

        flags_next.second     = flags.second     & ~clr.second;
        flags_next.delay_done = flags.delay_done & ~clr.delay_done;
        flags_next.slice      = flags.slice      & ~clr.slice;
        flags_next.long_pause = flags.long_pause & ~clr.long_pause;
        flags_next.period     = flags.period     & ~clr.period;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_count_reg  <= '0;
            delay_count_reg   <= '0;
            pattern_count_reg <= '0;
            slice_count_reg   <= '0;
            flags_reg         <= '0;
        end
        else if (en)
        begin
            second_count_reg  <= second_count_next;
            delay_count_reg   <= delay_count_next;
            pattern_count_reg <= pattern_count_next;
            slice_count_reg   <= slice_count_next;
            flags_reg         <= flags_next;
        end
    end

endmodule

// ----- rtl/cdt_ctrl.sv -----
// Mode controller, alarm beep sequencer and preset/countdown logic.
// Consumes one tick per enable and produces that tick's result. Depends on cdt_pkg.
module cdt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [1:0]           button_event,
    input  cdt_pkg::tick_flags_t flags,
    output cdt_pkg::tick_clear_t clr,
    output cdt_pkg::result_t     result
);

    logic [1:0]      pending_reg, pending_next;
    logic [6:0]      count_reg, count_next;
    cdt_pkg::mode_t  mode_reg, mode_next;
    cdt_pkg::phase_t phase_reg, phase_next;

    logic [1:0]     pend_c;
    cdt_pkg::mode_t mode_c;
    logic [6:0]     count_c;
    logic           rst_load, go_delay, go_run, click, dec, alarm;
    logic           tone_next, slice_clr, long_clr, period_clr;

    // Next state: controller, then alarm sequencer, then preset clicks and countdown.
    always_comb
    begin
        pend_c   = pending_reg;
        mode_c   = mode_reg;
        count_c  = count_reg;
        rst_load = 1'b0;
        go_delay = 1'b0;
        go_run   = 1'b0;

        if (button_event == cdt_pkg::EV_CLICK || button_event == cdt_pkg::EV_LONG)
            pend_c = button_event;

        unique case (mode_reg)
            cdt_pkg::MODE_RESET:
            begin
                count_c  = cdt_pkg::PRESET_90;
                rst_load = 1'b1;
                if (pend_c == cdt_pkg::EV_CLICK)
                begin
                    mode_c   = cdt_pkg::MODE_DELAY;
                    go_delay = 1'b1;
                    pend_c   = cdt_pkg::EV_NONE;
                end
            end
            cdt_pkg::MODE_DELAY:
            begin
                if (flags.delay_done)
                begin
                    mode_c = cdt_pkg::MODE_RUN;
                    go_run = 1'b1;
                    pend_c = cdt_pkg::EV_NONE;
                end
            end
            cdt_pkg::MODE_RUN:
            begin
                if (pend_c == cdt_pkg::EV_LONG)
                begin
                    mode_c = cdt_pkg::MODE_RESET;
                    pend_c = cdt_pkg::EV_NONE;
                end
                else if (count_reg == 7'd0)
                    mode_c = cdt_pkg::MODE_ALARM;
            end
            cdt_pkg::MODE_ALARM:
            begin
                if (pend_c == cdt_pkg::EV_LONG)
                begin
                    mode_c = cdt_pkg::MODE_RESET;
                    pend_c = cdt_pkg::EV_NONE;
                end
            end
            cdt_pkg::MODE_RESTART:
            begin
                if (pend_c == cdt_pkg::EV_CLICK)
                begin
                    mode_c = cdt_pkg::MODE_RESET;
                    pend_c = cdt_pkg::EV_NONE;
                end
            end
            default:
            begin
            end
        endcase

        // Beep pattern; the gate follows the phase held before this tick.
        alarm      = (mode_c == cdt_pkg::MODE_ALARM);
        phase_next = phase_reg;
        tone_next  = 1'b0;
        slice_clr  = 1'b0;
        long_clr   = 1'b0;
        period_clr = 1'b0;
        unique case (phase_reg)
            cdt_pkg::PH_STOP:
            begin
                if (alarm)
                    phase_next = cdt_pkg::PH_SOUND;
            end
            cdt_pkg::PH_SOUND, cdt_pkg::PH_SLICE_OFF:
            begin
                tone_next = (phase_reg == cdt_pkg::PH_SOUND);
                if (!alarm)
                    phase_next = cdt_pkg::PH_STOP;
                else if (flags.slice)
                begin
                    phase_next = (phase_reg == cdt_pkg::PH_SOUND) ?
                                 cdt_pkg::PH_SLICE_OFF : cdt_pkg::PH_SOUND;
                    slice_clr  = 1'b1;
                end
                else if (flags.long_pause)
                begin
                    phase_next = cdt_pkg::PH_LONG_OFF;
                    long_clr   = 1'b1;
                end
            end
            cdt_pkg::PH_LONG_OFF:
            begin
                if (!alarm)
                    phase_next = cdt_pkg::PH_STOP;
                else if (flags.period)
                begin
                    phase_next = cdt_pkg::PH_SOUND;
                    period_clr = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        mode_next    = mode_c;
        pending_next = pend_c;
        count_next   = count_c;
        click        = (pend_c == cdt_pkg::EV_CLICK) && (mode_c == cdt_pkg::MODE_DELAY);
        if (click)
        begin
            pending_next = cdt_pkg::EV_NONE;
            priority if (count_c == cdt_pkg::PRESET_90)
                count_next = cdt_pkg::PRESET_60;
            else if (count_c == cdt_pkg::PRESET_60)
                count_next = cdt_pkg::PRESET_45;
            else if (count_c == cdt_pkg::PRESET_45)
                count_next = cdt_pkg::PRESET_30;
            else if (count_c == cdt_pkg::PRESET_30)
                count_next = cdt_pkg::PRESET_15;
            else
            begin
                count_next = 7'd0;
                mode_next  = cdt_pkg::MODE_RESTART;
            end
        end

        dec = flags.second && !go_delay && !go_run && !click
              && (mode_next == cdt_pkg::MODE_RUN);
        if (dec && count_next != 7'd0)
            count_next = count_next - 7'd1;
    end

    // Outputs: flag clears back to the tick counters and the result of this tick.
    always_comb
    begin
        clr.delay_count = rst_load | click;
        clr.second      = go_delay | go_run | click | dec;
        clr.delay_done  = rst_load | go_run | click;
        clr.slice       = slice_clr;
        clr.long_pause  = long_clr;
        clr.period      = period_clr;

        result.seconds_left  = count_next;
        result.tens_digit_on = (count_next >= cdt_pkg::TENS_MIN);
        result.timer_mode    = mode_next;
        result.tone_enable   = tone_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= cdt_pkg::EV_NONE;
            count_reg   <= cdt_pkg::PRESET_90;
            mode_reg    <= cdt_pkg::MODE_RESET;
            phase_reg   <= cdt_pkg::PH_STOP;
        end
        else if (en)
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

// ----- rtl/countdown_timer_with_alarm_pattern.sv -----
// Countdown timer with alarm beep pattern: one input transaction per millisecond tick,
// one result transaction per tick. An accepted tick sits in the input register, passes the
// controller combinationally, and its result is registered into the output register and
// presented from there. A new tick is taken every cycle while the result side keeps
// up; a stalled result holds the tick in the input register and then stalls the input.
// Write configuration only while no tick is in flight.
// Depends on cdt_pkg, cdt_ticks and cdt_ctrl.
module countdown_timer_with_alarm_pattern (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            button_valid,
    output logic                            button_stall,
    input  logic [1:0]                      button_event,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [6:0]                      seconds_left,
    output logic                            tens_digit_on,
    output logic [2:0]                      timer_mode,
    output logic                            tone_enable,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);

    logic [15:0] second_ticks_reg, start_delay_ticks_reg;
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_event_reg;
    logic        out_valid_reg, out_valid_next;
    cdt_pkg::result_t out_reg, result_c;
    cdt_pkg::tick_flags_t flags;
    cdt_pkg::tick_clear_t clr;

    logic out_free, advance, accept;

    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign button_stall = in_valid_reg && !out_free;
    assign accept       = button_valid && !button_stall;

    always_comb
    begin
        in_valid_next = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_ticks_reg      <= cdt_pkg::SECOND_TICKS_RST;
            start_delay_ticks_reg <= cdt_pkg::START_DELAY_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == cdt_pkg::CFG_SECOND_TICKS)
                second_ticks_reg <= cfg_data;
            else if (cfg_index == cdt_pkg::CFG_START_DELAY_TICKS)
                start_delay_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_event_reg <= button_event;
        if (advance)
            out_reg <= result_c;
    end

    cdt_ticks u_ticks (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (advance),
        .second_ticks      (second_ticks_reg),
        .start_delay_ticks (start_delay_ticks_reg),
        .clr               (clr),
        .flags             (flags)
    );

    cdt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .button_event (in_event_reg),
        .flags        (flags),
        .clr          (clr),
        .result       (result_c)
    );

    assign result_valid  = out_valid_reg;
    assign seconds_left  = out_reg.seconds_left;
    assign tens_digit_on = out_reg.tens_digit_on;
    assign timer_mode    = out_reg.timer_mode;
    assign tone_enable   = out_reg.tone_enable;

endmodule

// ----- rtl/cdt_checker.sv -----
// Port-level checks for the countdown timer, bound to the top level.
// Depends on assert_macros.svh and cdt_pkg.
`include "assert_macros.svh"

module cdt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       button_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [6:0] seconds_left,
    input logic       tens_digit_on,
    input logic [2:0] timer_mode,
    input logic       tone_enable
);

    logic        out_held;
    logic [11:0] res_bits;
    logic        tens_ok;
    logic        count_ok;
    logic        restart_bad;

    assign out_held    = result_valid && result_stall;
    assign res_bits    = {seconds_left, tens_digit_on, timer_mode, tone_enable};
    assign tens_ok     = tens_digit_on == (seconds_left >= cdt_pkg::TENS_MIN);
    assign count_ok    = seconds_left <= cdt_pkg::PRESET_90;
    // Restart is only reached by stepping the preset past 15, which leaves zero.
    assign restart_bad = (timer_mode == cdt_pkg::MODE_RESTART) && (seconds_left != 7'd0);

    // A stalled result transaction stays put.
    `ASSERT_NEXT(a_hold, clk, rst_n, out_held, result_valid && $stable(res_bits), "stall hold")

    `ASSERT_IMPLY(a_tens_digit, clk, rst_n, result_valid, tens_ok, "tens flag mismatch")

    `ASSERT_IMPLY(a_count_range, clk, rst_n, result_valid, count_ok, "count above preset")

    `ASSERT_IMPLY(a_restart_zero, clk, rst_n, result_valid, !restart_bad, "restart count nonzero")

    // Input only backs up behind a full, stalled output register.
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, button_stall, out_held, "stall without result stall")

endmodule

bind countdown_timer_with_alarm_pattern cdt_checker u_cdt_checker (.*);

// ----- sim/cdt_result_checker.sv -----
// Result checker for countdown_timer_with_alarm_pattern: watches the tick, result and
// config channels, predicts each tick's readout and compares it field by field.
// Depends on cdt_pkg.
`timescale 1ns / 100ps

module cdt_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            button_valid,
    input  logic                            button_stall,
    input  logic [1:0]                      button_event,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic [6:0]                      seconds_left,
    input  logic                            tens_digit_on,
    input  logic [2:0]                      timer_mode,
    input  logic                            tone_enable,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    output int                              mismatch_count,
    output int                              pending_count,
    output int                              result_count
);

    localparam int SLICE_TICKS = 50;

    // Predicted timer state and register copies
    logic [15:0]      sec_ticks_cfg;
    logic [15:0]      delay_ticks_cfg;
    logic [15:0]      sec_cnt;
    logic [15:0]      win_cnt;
    logic [9:0]       pat_cnt;
    logic             sec_f;
    logic             win_f;
    logic             slice_f;
    logic             pause_f;
    logic             period_f;
    logic [1:0]       held_ev;
    logic [6:0]       secs;
    cdt_pkg::mode_t   mode_q;
    cdt_pkg::phase_t  phase_q;
    logic             tone_q;

    cdt_pkg::result_t due_readouts[$];
    int               mismatches;
    int               compared;

    task automatic step_timer(input logic [1:0] ev, output cdt_pkg::result_t res);
        logic in_alarm;
        if (ev == cdt_pkg::EV_CLICK || ev == cdt_pkg::EV_LONG)
            held_ev = ev;

        // free-running tick counters
        sec_cnt = sec_cnt + 16'd1;
        if (sec_cnt >= sec_ticks_cfg)
        begin
            sec_cnt = '0;
            sec_f   = 1'b1;
        end
        win_cnt = win_cnt + 16'd1;
        if (win_cnt >= delay_ticks_cfg)
        begin
            win_cnt = '0;
            win_f   = 1'b1;
        end
        pat_cnt = pat_cnt + 10'd1;
        if (pat_cnt % SLICE_TICKS == 0)
            slice_f = 1'b1;
        if (pat_cnt == cdt_pkg::LONG_PAUSE_AT)
            pause_f = 1'b1;
        if (pat_cnt >= cdt_pkg::PERIOD_TICKS)
        begin
            pat_cnt  = '0;
            period_f = 1'b1;
        end

        // mode controller
        case (mode_q)
            cdt_pkg::MODE_RESET:
            begin
                secs    = cdt_pkg::PRESET_90;
                win_cnt = '0;
                win_f   = 1'b0;
                if (held_ev == cdt_pkg::EV_CLICK)
                begin
                    mode_q  = cdt_pkg::MODE_DELAY;
                    sec_f   = 1'b0;
                    held_ev = cdt_pkg::EV_NONE;
                end
            end
            cdt_pkg::MODE_DELAY:
            begin
                if (win_f)
                begin
                    sec_f   = 1'b0;
                    win_f   = 1'b0;
                    held_ev = cdt_pkg::EV_NONE;
                    mode_q  = cdt_pkg::MODE_RUN;
                end
            end
            cdt_pkg::MODE_RUN:
            begin
                if (held_ev == cdt_pkg::EV_LONG)
                begin
                    mode_q  = cdt_pkg::MODE_RESET;
                    held_ev = cdt_pkg::EV_NONE;
                end
                else if (secs == 7'd0)
                    mode_q = cdt_pkg::MODE_ALARM;
            end
            cdt_pkg::MODE_ALARM:
            begin
                if (held_ev == cdt_pkg::EV_LONG)
                begin
                    mode_q  = cdt_pkg::MODE_RESET;
                    held_ev = cdt_pkg::EV_NONE;
                end
            end
            cdt_pkg::MODE_RESTART:
            begin
                if (held_ev == cdt_pkg::EV_CLICK)
                begin
                    mode_q  = cdt_pkg::MODE_RESET;
                    held_ev = cdt_pkg::EV_NONE;
                end
            end
            default:
            begin
            end
        endcase

        // beep pattern; tone follows the phase held on entry
        in_alarm = (mode_q == cdt_pkg::MODE_ALARM);
        case (phase_q)
            cdt_pkg::PH_STOP:
            begin
                tone_q = 1'b0;
                if (in_alarm)
                    phase_q = cdt_pkg::PH_SOUND;
            end
            cdt_pkg::PH_SOUND, cdt_pkg::PH_SLICE_OFF:
            begin
                tone_q = (phase_q == cdt_pkg::PH_SOUND);
                if (!in_alarm)
                    phase_q = cdt_pkg::PH_STOP;
                else if (slice_f)
                begin
                    if (phase_q == cdt_pkg::PH_SOUND)
                        phase_q = cdt_pkg::PH_SLICE_OFF;
                    else
                        phase_q = cdt_pkg::PH_SOUND;
                    slice_f = 1'b0;
                end
                else if (pause_f)
                begin
                    phase_q = cdt_pkg::PH_LONG_OFF;
                    pause_f = 1'b0;
                end
            end
            default:
            begin
                tone_q = 1'b0;
                if (!in_alarm)
                    phase_q = cdt_pkg::PH_STOP;
                else if (period_f)
                begin
                    phase_q  = cdt_pkg::PH_SOUND;
                    period_f = 1'b0;
                end
            end
        endcase

        // preset stepping, then the once-per-second decrement
        if (held_ev == cdt_pkg::EV_CLICK && mode_q == cdt_pkg::MODE_DELAY)
        begin
            case (secs)
                cdt_pkg::PRESET_90: secs = cdt_pkg::PRESET_60;
                cdt_pkg::PRESET_60: secs = cdt_pkg::PRESET_45;
                cdt_pkg::PRESET_45: secs = cdt_pkg::PRESET_30;
                cdt_pkg::PRESET_30: secs = cdt_pkg::PRESET_15;
                default:
                begin
                    secs   = 7'd0;
                    mode_q = cdt_pkg::MODE_RESTART;
                end
            endcase
            win_cnt = '0;
            sec_f   = 1'b0;
            win_f   = 1'b0;
            held_ev = cdt_pkg::EV_NONE;
        end
        if (sec_f && mode_q == cdt_pkg::MODE_RUN)
        begin
            if (secs > 7'd0)
                secs = secs - 7'd1;
            sec_f = 1'b0;
        end

        res.seconds_left  = secs;
        res.tens_digit_on = (secs >= cdt_pkg::TENS_MIN);
        res.timer_mode    = mode_q;
        res.tone_enable   = tone_q;
    endtask

    function automatic void check_field(input string field, input int want, input logic [6:0] got);
        if (got !== 7'(want))
        begin
            $error("result %0d: %s expected %0d, got %0d", compared, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cdt_pkg::result_t want;
        if (!rst_n)
        begin
            sec_ticks_cfg   = cdt_pkg::SECOND_TICKS_RST;
            delay_ticks_cfg = cdt_pkg::START_DELAY_TICKS_RST;
            sec_cnt         = '0;
            win_cnt         = '0;
            pat_cnt         = '0;
            sec_f           = 1'b0;
            win_f           = 1'b0;
            slice_f         = 1'b0;
            pause_f         = 1'b0;
            period_f        = 1'b0;
            held_ev         = cdt_pkg::EV_NONE;
            secs            = cdt_pkg::PRESET_90;
            mode_q          = cdt_pkg::MODE_RESET;
            phase_q         = cdt_pkg::PH_STOP;
            tone_q          = 1'b0;
            due_readouts.delete();
            mismatches      = 0;
            compared        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cdt_pkg::CFG_SECOND_TICKS)
                    sec_ticks_cfg = cfg_data;
                else if (cfg_index == cdt_pkg::CFG_START_DELAY_TICKS)
                    delay_ticks_cfg = cfg_data;
            end
            if (button_valid && !button_stall)
            begin
                step_timer(button_event, want);
                due_readouts.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                if (due_readouts.size() == 0)
                begin
                    $error("result %0d arrived with no tick outstanding", compared);
                    mismatches++;
                end
                else
                begin
                    want = due_readouts.pop_front();
                    check_field("seconds_left", want.seconds_left, seconds_left);
                    check_field("tens_digit_on", want.tens_digit_on, 7'(tens_digit_on));
                    check_field("timer_mode", want.timer_mode, 7'(timer_mode));
                    check_field("tone_enable", want.tone_enable, 7'(tone_enable));
                end
                compared++;
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= due_readouts.size();
        result_count   <= compared;
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for countdown_timer_with_alarm_pattern: clock, reset, tick and config
// stimulus with random idling, and the verdict. Depends on cdt_pkg, the block and
// cdt_result_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] EV_RESERVED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            button_valid = 1'b0;
    logic                            button_stall;
    logic [1:0]                      button_event = cdt_pkg::EV_NONE;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic [6:0]                      seconds_left;
    logic                            tens_digit_on;
    logic [2:0]                      timer_mode;
    logic                            tone_enable;
    logic                            cfg_valid    = 1'b0;
    logic                            cfg_ready;
    logic [cdt_pkg::CFG_INDEX_W-1:0] cfg_index    = cdt_pkg::CFG_SECOND_TICKS;
    logic [15:0]                     cfg_data     = '0;

    int mismatch_count;
    int pending_count;
    int result_count;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cur_st      = 1000;
    int cur_sd      = 5000;
    int ticks_sent  = 0;
    int phase_end   = 0;
    int settings    = 0;
    int cycles      = 0;

    countdown_timer_with_alarm_pattern u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .button_valid  (button_valid),
        .button_stall  (button_stall),
        .button_event  (button_event),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .seconds_left  (seconds_left),
        .tens_digit_on (tens_digit_on),
        .timer_mode    (timer_mode),
        .tone_enable   (tone_enable),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cdt_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .button_valid   (button_valid),
        .button_stall   (button_stall),
        .button_event   (button_event),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .seconds_left   (seconds_left),
        .tens_digit_on  (tens_digit_on),
        .timer_mode     (timer_mode),
        .tone_enable    (tone_enable),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[countdown_timer_with_alarm_pattern] ERROR");
            $finish;
        end
    end

    // One tick transaction, with an optional random gap ahead of it
    task automatic send_tick(input logic [1:0] ev);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            button_valid <= 1'b0;
            @(posedge clk);
        end
        button_valid <= 1'b1;
        button_event <= ev;
        @(posedge clk);
        while (button_stall)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic send_quiet(input int n);
        repeat (n)
            send_tick(cdt_pkg::EV_NONE);
    endtask

    // Hold off until every outstanding result is back
    task automatic wait_idle();
        button_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [cdt_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_phase(input int st, input int sd, input int idle, input int stall);
        wait_idle();
        write_reg(cdt_pkg::CFG_SECOND_TICKS, 16'(st));
        write_reg(cdt_pkg::CFG_START_DELAY_TICKS, 16'(sd));
        cur_st    = st;
        cur_sd    = sd;
        idle_pct  = idle;
        stall_pct = stall;
        settings++;
    endtask

    // Click into the window, step the preset, let it run (often into the alarm),
    // then long-press out; some noise and stray clicks mixed in.
    task automatic run_session();
        int clicks;
        int gap_max;
        int hold;
        int room;
        clicks  = $urandom_range(5);
        gap_max = (cur_sd >= 2) ? ((cur_sd - 2 > 6) ? 6 : cur_sd - 2) : 0;
        send_tick(cdt_pkg::EV_CLICK);
        repeat (clicks)
        begin
            send_quiet($urandom_range(gap_max));
            send_tick(cdt_pkg::EV_CLICK);
        end
        if (cur_st <= 4 && cur_sd <= 64 && $urandom_range(1) == 1)
            hold = 90 * cur_st + cur_sd + $urandom_range(20, 100);
        else
            hold = $urandom_range(30);
        // keep the phase near its tick budget
        room = phase_end - ticks_sent;
        if (room < 0)
            room = 0;
        if (hold > room)
            hold = room;
        send_quiet(hold);
        if ($urandom_range(9) < 2)
            repeat ($urandom_range(1, 8))
                send_tick(2'($urandom_range(3)));
        send_tick(cdt_pkg::EV_LONG);
        send_quiet($urandom_range(3));
        if ($urandom_range(1) == 1)
            send_tick(cdt_pkg::EV_CLICK);
    endtask

    task automatic run_phase(input int n);
        phase_end = ticks_sent + n;
        while (ticks_sent < phase_end)
            run_session();
    endtask

    initial
    begin
        logic [1:0] directed[$];
        // long held in reset, click replaces it; long held in delay, dropped at expiry;
        // run back to reset; restart: long held, click replaces
        directed = '{EV_RESERVED, cdt_pkg::EV_NONE,
                     cdt_pkg::EV_LONG, cdt_pkg::EV_CLICK,
                     cdt_pkg::EV_LONG, cdt_pkg::EV_NONE, cdt_pkg::EV_NONE, cdt_pkg::EV_NONE,
                     cdt_pkg::EV_LONG,
                     cdt_pkg::EV_CLICK, cdt_pkg::EV_CLICK, cdt_pkg::EV_CLICK,
                     cdt_pkg::EV_CLICK, cdt_pkg::EV_CLICK, cdt_pkg::EV_CLICK,
                     cdt_pkg::EV_NONE, cdt_pkg::EV_LONG, cdt_pkg::EV_CLICK,
                     cdt_pkg::EV_CLICK, cdt_pkg::EV_NONE, cdt_pkg::EV_NONE,
                     cdt_pkg::EV_NONE, cdt_pkg::EV_NONE};

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(1, 3, 0, 0);
        foreach (directed[i])
            send_tick(directed[i]);

        set_phase(1, 2, 0, 0);
        run_phase(120);
        set_phase(2, 9, 84, 0);
        run_phase(60);
        wait_idle();
        run_phase(60);
        set_phase(1, 1, 0, 84);
        run_phase(120);
        set_phase(1, 6, 8, 8);
        run_phase(120);
        set_phase(65535, 65535, 0, 0);
        run_phase(45);
        set_phase(3, 4, 0, 0);
        run_phase(120);

        wait_idle();
        $display("Summary: %0d ticks sent under %0d register settings, %0d results compared",
                 ticks_sent, settings, result_count);
        $display("         with idle and stall phases on both channels.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("[countdown_timer_with_alarm_pattern] OK");
        else
            $display("[countdown_timer_with_alarm_pattern] ERROR");
        $finish;
    end

endmodule
